[rtl/core/ctra_pkg.sv]
// Shared types and constants for the connection table with round aging.
package ctra_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int CNT_W        = 6;
	localparam logic [63:0] HASH_GOLDEN = 64'h0000_0000_9e37_79b9;
	localparam logic [5:0]  CNT_MAX     = 6'd63;

	localparam logic [2:0] KIND_INSERTED = 3'd0;
	localparam logic [2:0] KIND_UPDATED  = 3'd1;
	localparam logic [2:0] KIND_DOUBLE   = 3'd2;
	localparam logic [2:0] KIND_LOCAL    = 3'd3;
	localparam logic [2:0] KIND_FULL     = 3'd4;
	localparam logic [2:0] KIND_EXPIRED  = 3'd5;
	localparam logic [2:0] KIND_SUMMARY  = 3'd6;

	typedef struct packed {
		logic        valid;
		logic        seen;
		logic [63:0] key;
		logic [7:0]  protocol;
		logic [31:0] payload;
	} entry_t;

endpackage

[rtl/core/connection_table_round_aging_core.sv]
// Connection table with round aging: hash unit, slot ring and sequencer.
// Stash: accept, hash (more steps for IPv6 than IPv4), check, search over every slot, resolve
// and an update pass over every slot; equal endpoints end after the check, a full table after
// the resolve, and the resolve (and the check of equal endpoints) waits while the output stalls.
// Finish round: a ring pass over every slot, then the summary, longer while the output stalls.
// One item at a time; the ring rotates one slot per cycle (unless a sweep stalls) past a single head comparator.
// Asynchronous reset empties the table and clears the round counters at once.
module connection_table_round_aging_core #(
	parameter int CAPACITY = ctra_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic        family_is_v4,
	input  logic [7:0]  protocol,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [63:0] src_addr_lo,
	input  logic [63:0] src_addr_hi,
	input  logic [63:0] dst_addr_lo,
	input  logic [63:0] dst_addr_hi,
	input  logic [31:0] payload_ref,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [63:0] key,
	output logic [7:0]  entry_protocol,
	output logic [31:0] entry_payload,
	output logic [5:0]  added_count,
	output logic [5:0]  updated_count,
	output logic [5:0]  evicted_count,
	output logic [5:0]  remaining_count,
	output logic        last
);
	import ctra_pkg::*;

	localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(CAPACITY - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_HASH, S_DECIDE, S_SEARCH, S_RESOLVE, S_APPLY, S_SWEEP, S_SUMMARY
	} state_t;

	state_t      state_q;
	logic        v4_q;
	logic [7:0]  protocol_q;
	logic [15:0] src_port_q;
	logic [15:0] dst_port_q;
	logic [63:0] src_lo_q, src_hi_q, dst_lo_q, dst_hi_q;
	logic [31:0] payload_q;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] target_q;
	logic             hit_q, hit_seen_q, free_q, insert_q;
	logic [CNT_W-1:0] added_q, updated_q, expired_q, remain_q;

	logic             out_valid_q;
	logic [2:0]       kind_q;
	logic [63:0]      key_q;
	logic [7:0]       eproto_q;
	logic [31:0]      epay_q;
	logic [CNT_W-1:0] acnt_q, ucnt_q, ecnt_q, rcnt_q;
	logic             last_q;

	logic        accept, can_emit, shift, same, hash_start, hash_done;
	logic [63:0] hash_key;
	entry_t      head_new;
	entry_t      cell_q [CAPACITY];
	entry_t      cell_d [CAPACITY];

	assign accept     = in_valid && !in_stall;
	assign in_stall   = state_q != S_IDLE;
	assign can_emit   = !out_valid_q || !out_stall;
	assign hash_start = accept && !cmd;
	assign same = src_lo_q[31:0] == dst_lo_q[31:0] && (v4_q || (src_lo_q[63:32] ==
		dst_lo_q[63:32] && src_hi_q == dst_hi_q));

	ctra_hash u_hash (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (hash_start),
		.family_is_v4 (v4_q),
		.src_port     (hash_start ? src_port : src_port_q),
		.dst_port     (dst_port_q),
		.src_addr_lo  (src_lo_q),
		.src_addr_hi  (src_hi_q),
		.dst_addr_lo  (dst_lo_q),
		.dst_addr_hi  (dst_hi_q),
		.done         (hash_done),
		.key          (hash_key)
	);

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_ring
			if (gi == CAPACITY - 1) begin : g_tail
				assign cell_d[gi] = head_new;
			end else begin : g_link
				assign cell_d[gi] = cell_q[gi+1];
			end
			ctra_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (cell_d[gi]),
				.q      (cell_q[gi])
			);
		end
	endgenerate

	always_comb begin
		head_new = cell_q[0];
		shift    = 1'b0;
		unique case (state_q)
			S_SEARCH: shift = 1'b1;
			S_APPLY: begin
				shift = 1'b1;
				if (pos_q == target_q) begin
					head_new.seen     = 1'b1;
					head_new.protocol = protocol_q;
					head_new.payload  = payload_q;
					if (insert_q) begin
						head_new.valid = 1'b1;
						head_new.key   = hash_key;
					end
				end
			end
			S_SWEEP: begin
				head_new.seen = 1'b0;
				if (cell_q[0].valid && !cell_q[0].seen) begin
					head_new.valid = 1'b0;
					shift = can_emit;
				end else begin
					shift = 1'b1;
				end
			end
			default: shift = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v4_q       <= family_is_v4;
			protocol_q <= protocol;
			src_port_q <= src_port;
			dst_port_q <= dst_port;
			src_lo_q   <= src_addr_lo;
			src_hi_q   <= src_addr_hi;
			dst_lo_q   <= dst_addr_lo;
			dst_hi_q   <= dst_addr_hi;
			payload_q  <= payload_ref;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			target_q    <= '0;
			hit_q       <= 1'b0;
			hit_seen_q  <= 1'b0;
			free_q      <= 1'b0;
			insert_q    <= 1'b0;
			added_q     <= '0;
			updated_q   <= '0;
			expired_q   <= '0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= '0;
			key_q       <= '0;
			eproto_q    <= '0;
			epay_q      <= '0;
			acnt_q      <= '0;
			ucnt_q      <= '0;
			ecnt_q      <= '0;
			rcnt_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pos_q     <= '0;
						expired_q <= '0;
						remain_q  <= '0;
						state_q   <= cmd ? S_SWEEP : S_HASH;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					hit_q  <= 1'b0;
					free_q <= 1'b0;
					pos_q  <= '0;
					if (!same) begin
						state_q <= S_SEARCH;
					end else if (can_emit) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_LOCAL;
						key_q       <= hash_key;
						eproto_q    <= '0;
						epay_q      <= '0;
						acnt_q      <= '0;
						ucnt_q      <= '0;
						ecnt_q      <= '0;
						rcnt_q      <= '0;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_SEARCH: begin
					if (cell_q[0].valid && cell_q[0].key == hash_key && !hit_q) begin
						hit_q      <= 1'b1;
						hit_seen_q <= cell_q[0].seen;
						target_q   <= pos_q;
					end else if (!cell_q[0].valid && !free_q && !hit_q) begin
						free_q   <= 1'b1;
						target_q <= pos_q;
					end
					pos_q <= pos_q + POS_W'(1);
					if (pos_q == POS_LAST) begin
						pos_q   <= '0;
						state_q <= S_RESOLVE;
					end
				end
				S_RESOLVE: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						key_q       <= hash_key;
						eproto_q    <= '0;
						epay_q      <= '0;
						acnt_q      <= '0;
						ucnt_q      <= '0;
						ecnt_q      <= '0;
						rcnt_q      <= '0;
						last_q      <= 1'b1;
						insert_q    <= !hit_q;
						pos_q       <= '0;
						priority if (hit_q) begin
							kind_q    <= hit_seen_q ? KIND_DOUBLE : KIND_UPDATED;
							updated_q <= (updated_q == CNT_MAX) ? CNT_MAX : updated_q + 6'd1;
							state_q   <= S_APPLY;
						end else if (free_q) begin
							kind_q  <= KIND_INSERTED;
							added_q <= (added_q == CNT_MAX) ? CNT_MAX : added_q + 6'd1;
							state_q <= S_APPLY;
						end else begin
							kind_q  <= KIND_FULL;
							state_q <= S_IDLE;
						end
					end
				end
				S_APPLY: begin
					pos_q <= pos_q + POS_W'(1);
					if (pos_q == POS_LAST) begin
						pos_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_SWEEP: begin
					if (shift) begin
						if (cell_q[0].valid && !cell_q[0].seen) begin
							out_valid_q <= 1'b1;
							kind_q      <= KIND_EXPIRED;
							key_q       <= cell_q[0].key;
							eproto_q    <= cell_q[0].protocol;
							epay_q      <= cell_q[0].payload;
							acnt_q      <= '0;
							ucnt_q      <= '0;
							ecnt_q      <= '0;
							rcnt_q      <= '0;
							last_q      <= 1'b0;
							expired_q   <= expired_q + 6'd1;
						end else if (cell_q[0].valid) begin
							remain_q <= remain_q + 6'd1;
						end
						pos_q <= pos_q + POS_W'(1);
						if (pos_q == POS_LAST) begin
							pos_q   <= '0;
							state_q <= S_SUMMARY;
						end
					end
				end
				S_SUMMARY: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_SUMMARY;
						key_q       <= '0;
						eproto_q    <= '0;
						epay_q      <= '0;
						acnt_q      <= added_q;
						ucnt_q      <= updated_q;
						ecnt_q      <= expired_q;
						rcnt_q      <= remain_q;
						last_q      <= 1'b1;
						added_q     <= '0;
						updated_q   <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign key             = key_q;
	assign entry_protocol  = eproto_q;
	assign entry_payload   = epay_q;
	assign added_count     = acnt_q;
	assign updated_count   = ucnt_q;
	assign evicted_count   = ecnt_q;
	assign remaining_count = rcnt_q;
	assign last            = last_q;

endmodule

[rtl/core/ctra_cell.sv]
// One table slot of the rotating entry ring.
module ctra_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  ctra_pkg::entry_t d,
	output ctra_pkg::entry_t q
);
	import ctra_pkg::*;

	logic        valid_q;
	logic        seen_q;
	logic [63:0] key_q;
	logic [7:0]  protocol_q;
	logic [31:0] payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			seen_q  <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
			seen_q  <= d.seen;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q      <= d.key;
			protocol_q <= d.protocol;
			payload_q  <= d.payload;
		end
	end

	assign q = '{valid: valid_q, seen: seen_q, key: key_q, protocol: protocol_q,
		payload: payload_q};

endmodule

[rtl/core/ctra_hash.sv]
// Iterative key hash, one combine step per cycle.
module ctra_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        family_is_v4,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [63:0] src_addr_lo,
	input  logic [63:0] src_addr_hi,
	input  logic [63:0] dst_addr_lo,
	input  logic [63:0] dst_addr_hi,
	output logic        done,
	output logic [63:0] key
);
	import ctra_pkg::*;

	logic        busy_q;
	logic        first_q;
	logic [1:0]  word_q;
	logic [1:0]  part_q;
	logic [63:0] key_q;
	logic [31:0] src_w;
	logic [31:0] dst_w;
	logic [63:0] val;
	logic [63:0] mixed;
	logic        last_step;

	always_comb begin
		unique case (word_q)
			2'd0: begin src_w = src_addr_lo[31:0];  dst_w = dst_addr_lo[31:0];  end
			2'd1: begin src_w = src_addr_lo[63:32]; dst_w = dst_addr_lo[63:32]; end
			2'd2: begin src_w = src_addr_hi[31:0];  dst_w = dst_addr_hi[31:0];  end
			default: begin src_w = src_addr_hi[63:32]; dst_w = dst_addr_hi[63:32]; end
		endcase
		if (first_q || part_q == 2'd0) begin
			val = {48'd0, dst_port};
		end else if (part_q == 2'd1) begin
			val = {32'd0, src_w};
		end else begin
			val = {32'd0, dst_w};
		end
		mixed = key_q ^ (val + HASH_GOLDEN + (key_q << 6) + (key_q >> 2));
		last_step = !first_q && part_q == 2'd2 && (family_is_v4 || word_q == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			first_q <= 1'b0;
			word_q  <= '0;
			part_q  <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			first_q <= 1'b1;
			word_q  <= '0;
			part_q  <= '0;
		end else if (busy_q) begin
			if (first_q) begin
				first_q <= 1'b0;
			end else if (part_q == 2'd2) begin
				part_q <= '0;
				word_q <= word_q + 2'd1;
			end else begin
				part_q <= part_q + 2'd1;
			end
			if (last_step) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= {48'd0, src_port};
		end else if (busy_q) begin
			key_q <= mixed;
		end
	end

	assign done = busy_q && last_step;
	assign key  = key_q;

endmodule

[dv/tb_connection_table_round_aging_core.sv]
// Self-checking testbench for the connection table core: stash, refresh, sweep and table full.
`timescale 1ns / 100ps
module tb_connection_table_round_aging_core;
	import ctra_pkg::*;

	localparam int SLOTS = 32;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic        cmd;
		logic        family_is_v4;
		logic [7:0]  protocol;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [63:0] src_addr_lo;
		logic [63:0] src_addr_hi;
		logic [63:0] dst_addr_lo;
		logic [63:0] dst_addr_hi;
		logic [31:0] payload_ref;
	} conn_req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] key;
		logic [7:0]  entry_protocol;
		logic [31:0] entry_payload;
		logic [5:0]  added_count;
		logic [5:0]  updated_count;
		logic [5:0]  evicted_count;
		logic [5:0]  remaining_count;
		logic        last;
	} conn_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        out_valid;
	logic        out_stall;
	conn_req_t   drv;
	conn_rsp_t   mon;

	conn_req_t   pending_reqs[$];
	conn_rsp_t   expected_rsps[$];

	// model state
	logic        tbl_valid[SLOTS];
	logic        tbl_seen[SLOTS];
	logic [63:0] tbl_key[SLOTS];
	logic [7:0]  tbl_proto[SLOTS];
	logic [31:0] tbl_payload[SLOTS];
	logic [5:0]  cnt_added;
	logic [5:0]  cnt_updated;

	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_cycles;
	bit          hold_req;
	int          errors;
	int          beats_in;
	int          beats_out;
	int          idle_cycles;
	int          n_kind[8];

	connection_table_round_aging_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(drv.cmd), .family_is_v4(drv.family_is_v4), .protocol(drv.protocol),
		.src_port(drv.src_port), .dst_port(drv.dst_port),
		.src_addr_lo(drv.src_addr_lo), .src_addr_hi(drv.src_addr_hi),
		.dst_addr_lo(drv.dst_addr_lo), .dst_addr_hi(drv.dst_addr_hi),
		.payload_ref(drv.payload_ref),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(mon.kind), .key(mon.key), .entry_protocol(mon.entry_protocol),
		.entry_payload(mon.entry_payload), .added_count(mon.added_count),
		.updated_count(mon.updated_count), .evicted_count(mon.evicted_count),
		.remaining_count(mon.remaining_count), .last(mon.last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [63:0] mix_key(logic [63:0] k, logic [63:0] v);
		return k ^ (v + HASH_GOLDEN + (k << 6) + (k >> 2));
	endfunction

	function automatic logic [5:0] sat_inc(logic [5:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + 6'd1;
	endfunction

	function automatic conn_rsp_t make_rsp(logic [2:0] k, logic [63:0] hk, logic lst);
		conn_rsp_t r;
		r = '0;
		r.kind = k;
		r.key = hk;
		r.last = lst;
		return r;
	endfunction

	task automatic predict_table(input conn_req_t q);
		logic [31:0] sw, dw;
		logic [63:0] hk;
		logic        same;
		int          hit, free_idx, nwords, expired, remaining;
		conn_rsp_t   r;
		if (q.cmd) begin
			expired = 0;
			remaining = 0;
			for (int i = 0; i < SLOTS; i++) begin
				if (tbl_valid[i]) begin
					if (!tbl_seen[i]) begin
						r = make_rsp(KIND_EXPIRED, tbl_key[i], 1'b0);
						r.entry_protocol = tbl_proto[i];
						r.entry_payload = tbl_payload[i];
						expected_rsps.push_back(r);
						tbl_valid[i] = 1'b0;
						expired++;
					end else begin
						remaining++;
					end
					tbl_seen[i] = 1'b0;
				end
			end
			r = make_rsp(KIND_SUMMARY, 64'd0, 1'b1);
			r.added_count = cnt_added;
			r.updated_count = cnt_updated;
			r.evicted_count = 6'(expired);
			r.remaining_count = 6'(remaining);
			expected_rsps.push_back(r);
			cnt_added = '0;
			cnt_updated = '0;
			return;
		end
		nwords = q.family_is_v4 ? 1 : 4;
		same = 1'b1;
		hk = mix_key({48'd0, q.src_port}, {48'd0, q.dst_port});
		for (int w = 0; w < nwords; w++) begin
			sw = (w < 2) ? q.src_addr_lo[32*(w%2) +: 32] : q.src_addr_hi[32*(w%2) +: 32];
			dw = (w < 2) ? q.dst_addr_lo[32*(w%2) +: 32] : q.dst_addr_hi[32*(w%2) +: 32];
			if (sw != dw)
				same = 1'b0;
			hk = mix_key(hk, {48'd0, q.dst_port});
			hk = mix_key(hk, {32'd0, sw});
			hk = mix_key(hk, {32'd0, dw});
		end
		if (same) begin
			expected_rsps.push_back(make_rsp(KIND_LOCAL, hk, 1'b1));
			return;
		end
		hit = -1;
		free_idx = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (tbl_valid[i]) begin
				if (hit < 0 && tbl_key[i] == hk)
					hit = i;
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		if (hit >= 0) begin
			expected_rsps.push_back(make_rsp(tbl_seen[hit] ? KIND_DOUBLE : KIND_UPDATED, hk, 1'b1));
			cnt_updated = sat_inc(cnt_updated);
			tbl_seen[hit] = 1'b1;
			tbl_proto[hit] = q.protocol;
			tbl_payload[hit] = q.payload_ref;
		end else if (free_idx < 0) begin
			expected_rsps.push_back(make_rsp(KIND_FULL, hk, 1'b1));
		end else begin
			expected_rsps.push_back(make_rsp(KIND_INSERTED, hk, 1'b1));
			cnt_added = sat_inc(cnt_added);
			tbl_valid[free_idx] = 1'b1;
			tbl_seen[free_idx] = 1'b1;
			tbl_key[free_idx] = hk;
			tbl_proto[free_idx] = q.protocol;
			tbl_payload[free_idx] = q.payload_ref;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			drv <= '0;
		end else begin
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					drv <= pending_reqs.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
			hold_cycles <= 0;
		end else if (hold_req && hold_cycles == 0) begin
			hold_cycles <= 600;
			out_stall <= 1'b1;
		end else if (hold_cycles > 1) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			hold_cycles <= 0;
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			conn_rsp_t want;
			if (in_valid && !in_stall) begin
				predict_table(drv);
				beats_in++;
			end
			if (out_valid && !out_stall) begin
				beats_out++;
				n_kind[mon.kind]++;
				if (expected_rsps.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected beat: kind %0d key %h", mon.kind, mon.key);
				end else begin
					want = expected_rsps.pop_front();
					if (mon !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %p act %p", want, mon);
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > STALL_LIMIT) begin
				$display("timeout with %0d beats outstanding", expected_rsps.size());
				$display("tb_connection_table_round_aging_core: FAIL");
				$finish;
			end
		end
	end

	function automatic conn_req_t rand_req(bit sweep_ok, int pool);
		conn_req_t q;
		q.cmd = sweep_ok && ($urandom_range(99) < 8);
		q.family_is_v4 = 1'($urandom_range(1));
		q.protocol = 8'($urandom);
		// small port pool gives repeated keys
		q.src_port = (pool > 0) ? 16'($urandom_range(pool)) : 16'($urandom);
		q.dst_port = (pool > 0) ? 16'(80) : 16'($urandom);
		q.src_addr_lo = {$urandom, $urandom};
		q.src_addr_hi = {$urandom, $urandom};
		q.dst_addr_lo = {$urandom, $urandom};
		q.dst_addr_hi = {$urandom, $urandom};
		if (pool > 0) begin
			q.src_addr_lo = 64'h0a00_0001_0a00_0001;
			q.dst_addr_lo = 64'h0a00_0002_0a00_0002;
			q.src_addr_hi = 64'd7;
			q.dst_addr_hi = 64'd9;
		end
		if ($urandom_range(99) < 10) begin
			q.dst_addr_lo = q.src_addr_lo;
			q.dst_addr_hi = q.src_addr_hi;
		end
		q.payload_ref = $urandom;
		return q;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		conn_req_t q;
		errors = 0;
		beats_in = 0;
		beats_out = 0;
		idle_cycles = 0;
		hold_req = 0;
		send_idle_pct = 23;
		recv_idle_pct = 85;
		foreach (n_kind[i]) n_kind[i] = 0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_valid[i] = 0;
			tbl_seen[i] = 0;
			tbl_key[i] = '0;
			tbl_proto[i] = '0;
			tbl_payload[i] = '0;
		end
		cnt_added = '0;
		cnt_updated = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: sweep on empty, extremes, local, insert, double refresh, sweeps
		q = '0;
		q.cmd = 1'b1;
		pending_reqs.push_back(q);
		q = '0;
		q.family_is_v4 = 1'b1;
		pending_reqs.push_back(q);
		q = '1;
		q.cmd = 1'b0;
		q.family_is_v4 = 1'b0;
		pending_reqs.push_back(q);
		q.dst_addr_hi = 64'h0;
		pending_reqs.push_back(q);
		q.protocol = 8'h11;
		pending_reqs.push_back(q);
		pending_reqs.push_back(q);
		q.family_is_v4 = 1'b1;
		q.src_addr_lo = 64'hffff_ffff_0000_0001;
		q.dst_addr_lo = 64'h0000_0000_0000_0002;
		pending_reqs.push_back(q);
		q.dst_addr_lo = 64'h1234_5678_0000_0001;
		pending_reqs.push_back(q);
		q.cmd = 1'b1;
		pending_reqs.push_back(q);
		pending_reqs.push_back(q);
		pending_reqs.push_back(q);
		for (int i = 0; i < 36; i++)
			pending_reqs.push_back(rand_req(0, 0));
		q.cmd = 1'b1;
		pending_reqs.push_back(q);
		pending_reqs.push_back(q);
		wait_drained();

		// long receiver hold while the sender keeps offering
		hold_req = 1;
		wait (hold_cycles > 0);
		hold_req = 0;
		for (int i = 0; i < 17; i++)
			pending_reqs.push_back(rand_req(1, ($urandom_range(1)) ? 12 : 0));
		wait_drained();

		send_idle_pct = 85;
		recv_idle_pct = 23;
		for (int i = 0; i < 17; i++)
			pending_reqs.push_back(rand_req(1, ($urandom_range(1)) ? 12 : 0));
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 16; i++)
			pending_reqs.push_back(rand_req(1, ($urandom_range(1)) ? 12 : 0));
		q = '0;
		q.cmd = 1'b1;
		pending_reqs.push_back(q);
		wait_drained();
		repeat (100) @(posedge clk);

		$display("covered %0d items and %0d results: inserted %0d updated %0d double %0d",
			beats_in, beats_out, n_kind[KIND_INSERTED], n_kind[KIND_UPDATED],
			n_kind[KIND_DOUBLE]);
		$display("local %0d full %0d expired %0d summaries %0d, mismatches %0d",
			n_kind[KIND_LOCAL], n_kind[KIND_FULL], n_kind[KIND_EXPIRED],
			n_kind[KIND_SUMMARY], errors);
		if (errors == 0 && expected_rsps.size() == 0)
			$display("tb_connection_table_round_aging_core: PASS");
		else
			$display("tb_connection_table_round_aging_core: FAIL");
		$finish;
	end

endmodule

[files.f]
rtl/core/ctra_pkg.sv
rtl/core/ctra_cell.sv
rtl/core/ctra_hash.sv
rtl/core/connection_table_round_aging_core.sv
dv/tb_connection_table_round_aging_core.sv
